// ----- rtl/core/lbc_pkg.sv -----
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and codes for the LRU block buffer cache
// Field widths, entry record, cell control groups and status/mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

	// Default number of cache entries
	localparam int DEF_ENTRIES = 8;

	// Field widths
	localparam int MODE_W  = 2;
	localparam int DRIVE_W = 8;
	localparam int BLOCK_W = 16;
	localparam int INDEX_W = 3;
	localparam int STAT_W  = 3;
	localparam int TAG_W   = DRIVE_W + BLOCK_W;
	localparam int CNT_W   = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Request modes
	typedef enum logic [MODE_W-1:0] {
		MODE_ACQUIRE = 2'd0,
		MODE_MARK    = 2'd1,
		MODE_RELEASE = 2'd2
	} mode_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_VALID     = 3'd0,
		ST_FILL      = 3'd1,
		ST_RETRY     = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOTLOCKED = 3'd4
	} status_t;

	// State of one cache entry, apart from its identity
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             busy;
		logic             valid;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	// Registered request
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [TAG_W-1:0]   tag;
		logic [INDEX_W-1:0] index;
	} req_t;

	// Per-cell update command
	typedef struct packed {
		logic load;   // take the broadcast entry and identity
		logic shift;  // take the contents of the upper neighbour
	} cell_cmd_t;

	// Per-cell lookup flags
	typedef struct packed {
		logic match;  // tag equals the request tag
		logic free;   // neither locked nor referenced
		logic idsel;  // identity equals the request index
	} cell_flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/lbc_if.sv -----
// ----------------------------------------------------------------------------
// lbc_if: request and response channels of the LRU block buffer cache
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbc_req_if;
	logic                         valid;
	logic                         ready;
	logic [lbc_pkg::MODE_W-1:0]   mode;
	logic [lbc_pkg::DRIVE_W-1:0]  drive;
	logic [lbc_pkg::BLOCK_W-1:0]  block_addr;
	logic [lbc_pkg::INDEX_W-1:0]  buffer_index;

	modport source (output valid, mode, drive, block_addr, buffer_index, input ready);
	modport sink   (input valid, mode, drive, block_addr, buffer_index, output ready);
endinterface

interface lbc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [lbc_pkg::STAT_W-1:0]   status;
	logic [lbc_pkg::INDEX_W-1:0]  granted_index;

	modport source (output valid, status, granted_index, input ready);
	modport sink   (input valid, status, granted_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lbc_pick.sv -----
// ----------------------------------------------------------------------------
// lbc_pick: priority pick of the highest set bit
// Returns the position of the highest set bit of a flag row and whether any is set.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_pick #(
	parameter int N = lbc_pkg::DEF_ENTRIES
) (
	input  wire logic [N-1:0]         vec,
	output logic      [$clog2(N)-1:0] pos,
	output logic                      any
);

	localparam int IW = $clog2(N);

	// Scan upwards so the highest set bit wins
	always_comb begin
		pos = '0;
		any = 1'b0;
		for (int i = 0; i < N; i++) begin
			if (vec[i]) begin
				pos = IW'(i);
				any = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/lbc_cell.sv -----
// ----------------------------------------------------------------------------
// lbc_cell: one position of the recency chain
// Holds one entry and its identity; compares it against the request and
// loads a new entry or takes its upper neighbour's on a move.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_cell #(
	parameter int ENTRIES = lbc_pkg::DEF_ENTRIES,
	parameter int POS     = 0
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire lbc_pkg::cell_cmd_t                cmd,
	input  wire lbc_pkg::entry_t                   new_entry,
	input  wire logic [$clog2(ENTRIES)-1:0]        new_id,
	input  wire lbc_pkg::entry_t                   up_entry,
	input  wire logic [$clog2(ENTRIES)-1:0]        up_id,
	input  wire logic [lbc_pkg::TAG_W-1:0]         req_tag,
	input  wire logic [lbc_pkg::INDEX_W-1:0]       req_index,
	output lbc_pkg::entry_t                        entry,
	output logic      [$clog2(ENTRIES)-1:0]        id,
	output lbc_pkg::cell_flags_t                   flags
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CMP_W = (IDX_W > lbc_pkg::INDEX_W) ? IDX_W : lbc_pkg::INDEX_W;

	lbc_pkg::entry_t    entry_q;
	logic [IDX_W-1:0]   id_q;

	// Load, shift down from the neighbour, or hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			id_q    <= IDX_W'(POS);
		end else if (cmd.load) begin
			entry_q <= new_entry;
			id_q    <= new_id;
		end else if (cmd.shift) begin
			entry_q <= up_entry;
			id_q    <= up_id;
		end
	end

	// Local lookup against the current request
	always_comb begin
		flags.match = (entry_q.tag == req_tag);
		flags.free  = !entry_q.busy && (entry_q.cnt == '0);
		flags.idsel = (CMP_W'(id_q) == CMP_W'(req_index));
	end

	assign entry = entry_q;
	assign id    = id_q;

endmodule

`default_nettype wire

// ----- rtl/core/lru_block_buffer_cache.sv -----
// ----------------------------------------------------------------------------
// lru_block_buffer_cache: tag and lock manager for a disk block buffer cache
// Each request is first registered; then all cells compare their tag and
// identity in parallel, priority pickers choose the hit, victim or
// addressed entry, and the cells update. The cells are kept in recency
// order, lowest position least recent; making an entry most recent
// shifts the cells above it down one place and puts it on top.
// A new request is taken while the previous result waits on the response
// channel; a request is executed once the response register is free. There
// is no clearing pass: the chain comes out of reset ready.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_block_buffer_cache #(
	parameter int ENTRIES = lbc_pkg::DEF_ENTRIES
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lbc_req_if.sink    req,
	lbc_rsp_if.source  rsp
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int TOP   = ENTRIES - 1;

	lbc_pkg::req_t                 req_q;
	logic                          pend_q;
	logic                          rsp_valid_q;
	lbc_pkg::status_t              status_q;
	logic [lbc_pkg::INDEX_W-1:0]   gi_q;

	lbc_pkg::entry_t               cell_entry [ENTRIES];
	logic [IDX_W-1:0]              cell_id    [ENTRIES];
	lbc_pkg::cell_flags_t          cell_flags [ENTRIES];
	lbc_pkg::cell_cmd_t            cell_cmd   [ENTRIES];

	logic [ENTRIES-1:0]            match_vec;
	logic [ENTRIES-1:0]            free_rev;
	logic [ENTRIES-1:0]            idsel_vec;
	logic [IDX_W-1:0]              hit_pos;
	logic [IDX_W-1:0]              free_rev_pos;
	logic [IDX_W-1:0]              vic_pos;
	logic [IDX_W-1:0]              idx_pos;
	logic                          hit_any;
	logic                          free_any;
	logic                          idx_any;

	logic [IDX_W-1:0]              sel;
	lbc_pkg::entry_t               sel_e;
	logic [IDX_W-1:0]              sel_id;
	lbc_pkg::entry_t               new_e;
	lbc_pkg::status_t              status_d;
	logic [lbc_pkg::INDEX_W-1:0]   gi_d;
	logic                          upd;
	logic                          move;
	logic                          go;
	logic [lbc_pkg::CNT_W-1:0]     cnt_dec;

	// Handshake: take a request whenever none is pending
	assign req.ready = !pend_q;
	assign go        = pend_q && (!rsp_valid_q || rsp.ready);

	// Hold the request and the pending mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			req_q  <= '0;
		end else begin
			if (req.valid && req.ready) begin
				pend_q      <= 1'b1;
				req_q.mode  <= req.mode;
				req_q.tag   <= {req.drive, req.block_addr};
				req_q.index <= req.buffer_index;
			end else if (go) begin
				pend_q <= 1'b0;
			end
		end
	end

	// Row of cells in recency order
	for (genvar p = 0; p < ENTRIES; p++) begin : g_cell
		if (p < TOP) begin : g_mid
			lbc_cell #(.ENTRIES(ENTRIES), .POS(p)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cell_cmd[p]),
				.new_entry (new_e),
				.new_id    (sel_id),
				.up_entry  (cell_entry[p+1]),
				.up_id     (cell_id[p+1]),
				.req_tag   (req_q.tag),
				.req_index (req_q.index),
				.entry     (cell_entry[p]),
				.id        (cell_id[p]),
				.flags     (cell_flags[p])
			);
		end else begin : g_top
			lbc_cell #(.ENTRIES(ENTRIES), .POS(p)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cell_cmd[p]),
				.new_entry (new_e),
				.new_id    (sel_id),
				.up_entry  (new_e),
				.up_id     (sel_id),
				.req_tag   (req_q.tag),
				.req_index (req_q.index),
				.entry     (cell_entry[p]),
				.id        (cell_id[p]),
				.flags     (cell_flags[p])
			);
		end

		assign match_vec[p]     = cell_flags[p].match;
		assign free_rev[TOP-p]  = cell_flags[p].free;
		assign idsel_vec[p]     = cell_flags[p].idsel;

		// Top takes the moved entry; cells from the selected one upwards shift down
		assign cell_cmd[p].load  = go && ((upd && !move && (sel == IDX_W'(p))) ||
			(move && (p == TOP)));
		assign cell_cmd[p].shift = go && move && (p < TOP) && (sel <= IDX_W'(p));
	end

	// Most recent hit, least recent free entry, addressed entry
	lbc_pick #(.N(ENTRIES)) u_pick_hit  (.vec(match_vec), .pos(hit_pos),      .any(hit_any));
	lbc_pick #(.N(ENTRIES)) u_pick_free (.vec(free_rev),  .pos(free_rev_pos), .any(free_any));
	lbc_pick #(.N(ENTRIES)) u_pick_idx  (.vec(idsel_vec), .pos(idx_pos),      .any(idx_any));

	assign vic_pos = IDX_W'(TOP) - free_rev_pos;

	// Choose the position the request acts on
	always_comb begin
		if (req_q.mode == lbc_pkg::MODE_ACQUIRE) begin
			sel = hit_any ? hit_pos : vic_pos;
		end else begin
			sel = idx_pos;
		end
	end

	assign sel_e   = cell_entry[sel];
	assign sel_id  = cell_id[sel];
	assign cnt_dec = (sel_e.cnt == '0) ? '0 : sel_e.cnt - 1'b1;

	// Decide the result and the entry update
	always_comb begin
		new_e    = sel_e;
		upd      = 1'b0;
		move     = 1'b0;
		status_d = lbc_pkg::ST_NOTLOCKED;
		gi_d     = req_q.index;
		unique case (req_q.mode)
			lbc_pkg::MODE_ACQUIRE: begin
				if (hit_any) begin
					gi_d = lbc_pkg::INDEX_W'(sel_id);
					if (sel_e.busy) begin
						status_d = lbc_pkg::ST_RETRY;
					end else begin
						upd        = 1'b1;
						new_e.busy = 1'b1;
						if (sel_e.cnt != lbc_pkg::CNT_MAX) begin
							new_e.cnt = sel_e.cnt + 1'b1;
						end
						status_d = sel_e.valid ? lbc_pkg::ST_VALID : lbc_pkg::ST_FILL;
					end
				end else if (free_any) begin
					upd         = 1'b1;
					new_e.tag   = req_q.tag;
					new_e.cnt   = lbc_pkg::CNT_W'(1);
					new_e.busy  = 1'b1;
					new_e.valid = 1'b0;
					status_d    = lbc_pkg::ST_FILL;
					gi_d        = lbc_pkg::INDEX_W'(sel_id);
				end else begin
					status_d = lbc_pkg::ST_FULL;
					gi_d     = '0;
				end
			end
			lbc_pkg::MODE_MARK: begin
				if (idx_any && sel_e.busy) begin
					upd         = 1'b1;
					new_e.valid = 1'b1;
					status_d    = lbc_pkg::ST_VALID;
				end
			end
			lbc_pkg::MODE_RELEASE: begin
				if (idx_any && sel_e.busy) begin
					upd        = 1'b1;
					new_e.busy = 1'b0;
					new_e.cnt  = cnt_dec;
					move       = (cnt_dec == '0);
					status_d   = lbc_pkg::ST_VALID;
				end
			end
			default: begin
				status_d = lbc_pkg::ST_NOTLOCKED;
			end
		endcase
	end

	// Response register: load on execute, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			status_q    <= lbc_pkg::ST_VALID;
			gi_q        <= '0;
		end else begin
			if (go) begin
				rsp_valid_q <= 1'b1;
				status_q    <= status_d;
				gi_q        <= gi_d;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.granted_index = gi_q;

endmodule

`default_nettype wire

// ----- tb/lru_block_buffer_cache_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_test: self-checking bench for the block buffer cache
// Drives acquire, mark-valid, release and undefined requests with random
// gaps, stalls the response side at random, and compares every response
// with a tag, lock and recency predictor kept in step with each accepted request.
// ----------------------------------------------------------------------------

// Request code that the block does not define; answered as not locked
localparam logic [lbc_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

typedef struct packed {
	lbc_pkg::status_t            status;
	logic [lbc_pkg::INDEX_W-1:0] index;
} grant_t;

class cache_scoreboard;
	logic [lbc_pkg::TAG_W-1:0]   tags   [lbc_pkg::DEF_ENTRIES];
	logic                        locked [lbc_pkg::DEF_ENTRIES];
	logic                        filled [lbc_pkg::DEF_ENTRIES];
	logic [lbc_pkg::CNT_W-1:0]   refs   [lbc_pkg::DEF_ENTRIES];
	logic [lbc_pkg::INDEX_W-1:0] rank   [lbc_pkg::DEF_ENTRIES];
	grant_t                      grants_q[$];
	int unsigned                 errors;

	function new();
		errors = 0;
		for (int i = 0; i < lbc_pkg::DEF_ENTRIES; i++) begin
			tags[i]   = '0;
			locked[i] = 1'b0;
			filled[i] = 1'b0;
			refs[i]   = '0;
			rank[i]   = lbc_pkg::INDEX_W'(i);
		end
	endfunction

	function int unsigned outstanding();
		return grants_q.size();
	endfunction

	// Move one entry to the top of the recency order
	function void promote(int e);
		logic [lbc_pkg::INDEX_W-1:0] r;
		r = rank[e];
		for (int i = 0; i < lbc_pkg::DEF_ENTRIES; i++)
			if (rank[i] > r)
				rank[i] = rank[i] - 1'b1;
		rank[e] = lbc_pkg::INDEX_W'(lbc_pkg::DEF_ENTRIES - 1);
	endfunction

	// Advance the predicted state by one accepted request
	function void note_request(logic [lbc_pkg::MODE_W-1:0] mode,
	                           logic [lbc_pkg::DRIVE_W-1:0] drive,
	                           logic [lbc_pkg::BLOCK_W-1:0] blk,
	                           logic [lbc_pkg::INDEX_W-1:0] idx);
		grant_t                    g;
		logic [lbc_pkg::TAG_W-1:0] tag;
		int                        hit;
		int                        victim;
		tag     = {drive, blk};
		g.index = idx;
		hit     = -1;
		victim  = -1;
		if (mode == lbc_pkg::MODE_ACQUIRE) begin
			for (int i = 0; i < lbc_pkg::DEF_ENTRIES; i++)
				if (tags[i] == tag && (hit < 0 || rank[i] > rank[hit]))
					hit = i;
			if (hit >= 0) begin
				if (locked[hit]) begin
					g.status = lbc_pkg::ST_RETRY;
				end else begin
					locked[hit] = 1'b1;
					if (refs[hit] != lbc_pkg::CNT_MAX)
						refs[hit] = refs[hit] + 1'b1;
					g.status = filled[hit] ? lbc_pkg::ST_VALID : lbc_pkg::ST_FILL;
				end
				g.index = lbc_pkg::INDEX_W'(hit);
			end else begin
				for (int i = 0; i < lbc_pkg::DEF_ENTRIES; i++)
					if (!locked[i] && refs[i] == '0 &&
					    (victim < 0 || rank[i] < rank[victim]))
						victim = i;
				if (victim < 0) begin
					g.status = lbc_pkg::ST_FULL;
					g.index  = '0;
				end else begin
					// recycle: new tag, data not yet filled, rank kept
					tags[victim]   = tag;
					refs[victim]   = lbc_pkg::CNT_W'(1);
					locked[victim] = 1'b1;
					filled[victim] = 1'b0;
					g.status       = lbc_pkg::ST_FILL;
					g.index        = lbc_pkg::INDEX_W'(victim);
				end
			end
		end else if ((mode != lbc_pkg::MODE_MARK && mode != lbc_pkg::MODE_RELEASE) ||
		             !locked[idx]) begin
			g.status = lbc_pkg::ST_NOTLOCKED;
		end else if (mode == lbc_pkg::MODE_MARK) begin
			filled[idx] = 1'b1;
			g.status    = lbc_pkg::ST_VALID;
		end else begin
			locked[idx] = 1'b0;
			if (refs[idx] != '0)
				refs[idx] = refs[idx] - 1'b1;
			if (refs[idx] == '0)
				promote(int'(idx));
			g.status = lbc_pkg::ST_VALID;
		end
		grants_q.push_back(g);
	endfunction

	// Compare one response transfer with the oldest expectation
	function void check_response(logic [lbc_pkg::STAT_W-1:0] status,
	                             logic [lbc_pkg::INDEX_W-1:0] index);
		grant_t g;
		if (grants_q.size() == 0) begin
			$error("response with none expected: status %0d, granted_index %0d",
			       status, index);
			errors++;
			return;
		end
		g = grants_q.pop_front();
		if (status !== g.status) begin
			$error("status: expected %0d, got %0d", g.status, status);
			errors++;
		end
		if (index !== g.index) begin
			$error("granted_index: expected %0d, got %0d", g.index, index);
			errors++;
		end
	endfunction
endclass

module lru_block_buffer_cache_test;

	localparam int          RANDOM_ITEMS = 1350;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int          SETTLE       = 16;
	localparam int          POOL_SIZE    = 12;

	logic                      clk = 1'b0;
	logic                      arst_n;
	int unsigned               cycles = 0;
	bit                        gaps_en;
	bit                        stall_en;
	int unsigned               stall_left = 0;
	logic [lbc_pkg::TAG_W-1:0] tag_pool [POOL_SIZE];
	cache_scoreboard           sb;

	lbc_req_if req ();
	lbc_rsp_if rsp ();

	lru_block_buffer_cache u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watch both channels and count cycles
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (rsp.valid && rsp.ready)
				sb.check_response(rsp.status, rsp.granted_index);
			if (req.valid && req.ready)
				sb.note_request(req.mode, req.drive, req.block_addr, req.buffer_index);
		end
	end

	// Stall the response side: mostly short stalls, a few long ones
	always @(posedge clk) begin
		if (stall_left != 0) begin
			rsp.ready  <= 1'b0;
			stall_left  = stall_left - 1;
		end else begin
			rsp.ready <= 1'b1;
			if (stall_en && $urandom_range(0, 99) < 25) begin
				if ($urandom_range(0, 99) < 92)
					stall_left = $urandom_range(1, 4);
				else
					stall_left = $urandom_range(15, 40);
			end
		end
	end

	// Give up after the cycle limit
	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk);
		$display("lru_block_buffer_cache: mismatch");
		$finish;
	end

	function automatic int unsigned sender_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!gaps_en || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one request and hold it until the transfer
	task automatic send(logic [lbc_pkg::MODE_W-1:0] mode, logic [lbc_pkg::DRIVE_W-1:0] drive,
	                    logic [lbc_pkg::BLOCK_W-1:0] blk, logic [lbc_pkg::INDEX_W-1:0] idx);
		int unsigned gap;
		gap = sender_gap();
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid        <= 1'b1;
		req.mode         <= mode;
		req.drive        <= drive;
		req.block_addr   <= blk;
		req.buffer_index <= idx;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	// Hold off until every expected response has arrived
	task automatic drain();
		req.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.outstanding() != 0);
	endtask

	// Mostly reuse a small set of tags so hits, retries and recycling all occur
	task automatic send_random();
		logic [lbc_pkg::TAG_W-1:0]   tag;
		logic [lbc_pkg::MODE_W-1:0]  mode;
		logic [lbc_pkg::INDEX_W-1:0] idx;
		int unsigned                 r;
		int                          held[$];
		r = $urandom_range(0, 99);
		if (r < 50)
			mode = lbc_pkg::MODE_ACQUIRE;
		else if (r < 72)
			mode = lbc_pkg::MODE_MARK;
		else if (r < 96)
			mode = lbc_pkg::MODE_RELEASE;
		else
			mode = MODE_UNUSED;
		if ($urandom_range(0, 99) < 75)
			tag = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			tag = lbc_pkg::TAG_W'($urandom);
		idx = lbc_pkg::INDEX_W'($urandom);
		for (int i = 0; i < lbc_pkg::DEF_ENTRIES; i++)
			if (sb.locked[i])
				held.push_back(i);
		if (mode != lbc_pkg::MODE_ACQUIRE && held.size() != 0 && $urandom_range(0, 99) < 80)
			idx = lbc_pkg::INDEX_W'(held[$urandom_range(0, held.size() - 1)]);
		send(mode, tag[lbc_pkg::TAG_W-1:lbc_pkg::BLOCK_W], tag[lbc_pkg::BLOCK_W-1:0], idx);
	endtask

	initial begin
		sb               = new();
		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.mode         = lbc_pkg::MODE_ACQUIRE;
		req.drive        = '0;
		req.block_addr   = '0;
		req.buffer_index = '0;
		gaps_en          = 1'b1;
		stall_en         = 1'b1;
		tag_pool[0]      = '0;
		tag_pool[1]      = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			tag_pool[i] = lbc_pkg::TAG_W'($urandom);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset tags all match drive 0 block 0: hit the most recent one
		send(lbc_pkg::MODE_ACQUIRE, 8'h00, 16'h0000, 3'd0);
		// same tag again while locked: retry
		send(lbc_pkg::MODE_ACQUIRE, 8'h00, 16'h0000, 3'd0);
		send(lbc_pkg::MODE_MARK, 8'h00, 16'h0000, 3'd7);
		send(lbc_pkg::MODE_RELEASE, 8'h00, 16'h0000, 3'd7);
		// filled data now: granted valid
		send(lbc_pkg::MODE_ACQUIRE, 8'h00, 16'h0000, 3'd0);
		// mark and release of an unlocked entry, and the undefined code
		send(lbc_pkg::MODE_MARK, 8'hFF, 16'hFFFF, 3'd3);
		send(lbc_pkg::MODE_RELEASE, 8'hFF, 16'hFFFF, 3'd3);
		send(MODE_UNUSED, 8'h00, 16'h0000, 3'd5);
		// misses recycle the least recent free entries until none is left
		send(lbc_pkg::MODE_ACQUIRE, 8'hFF, 16'hFFFF, 3'd0);
		send(lbc_pkg::MODE_ACQUIRE, 8'h55, 16'hAAAA, 3'd0);
		send(lbc_pkg::MODE_ACQUIRE, 8'hAA, 16'h5555, 3'd0);
		send(lbc_pkg::MODE_ACQUIRE, 8'h01, 16'h0001, 3'd0);
		send(lbc_pkg::MODE_ACQUIRE, 8'h80, 16'h8000, 3'd0);
		send(lbc_pkg::MODE_ACQUIRE, 8'h7F, 16'h7FFF, 3'd0);
		send(lbc_pkg::MODE_ACQUIRE, 8'h02, 16'h1234, 3'd0);
		// every entry locked: cache full
		send(lbc_pkg::MODE_ACQUIRE, 8'h33, 16'hCCCC, 3'd0);
		for (int i = 0; i < lbc_pkg::DEF_ENTRIES; i++)
			send(lbc_pkg::MODE_RELEASE, 8'h00, 16'h0000, lbc_pkg::INDEX_W'(i));
		send(lbc_pkg::MODE_ACQUIRE, 8'hFF, 16'hFFFF, 3'd0);
		drain();

		// Random traffic in phases, with and without idling
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 200 == 0) begin
				gaps_en  = (n % 600) != 0;
				stall_en = (n % 400) != 200;
			end
			if (n % 450 == 449)
				drain();
			send_random();
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("lru_block_buffer_cache: match");
		else
			$display("lru_block_buffer_cache: mismatch");
		$finish;
	end

endmodule
